@@ src/lavm_pkg.sv @@
// shared types and constants for the look-at view matrix block
package lavm_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W = 32;
	localparam int DIFF_W = 33;
	localparam int VEC_W = 58;
	localparam int FIFO_DEPTH = 2;

	localparam logic [1:0] ROW_RIGHT = 2'd0;
	localparam logic [1:0] ROW_UP = 2'd1;
	localparam logic [1:0] ROW_LOOK = 2'd2;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] eye;
		logic [2:0][COORD_W-1:0] up;
		logic [2:0][DIFF_W-1:0] diff;
		logic deg;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NMAX,
		ST_NSHIFT,
		ST_SQ,
		ST_SQRT,
		ST_DIVI,
		ST_DIV,
		ST_CROSS,
		ST_UPN,
		ST_DOT,
		ST_ROW
	} back_state_t;

endpackage

@@ src/lavm_if.sv @@
// valid/ready channel interfaces for items and matrix rows
interface lavm_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] eye_x;
	logic signed [31:0] eye_y;
	logic signed [31:0] eye_z;
	logic signed [31:0] up_x;
	logic signed [31:0] up_y;
	logic signed [31:0] up_z;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] target_z;

	modport source(output valid, eye_x, eye_y, eye_z, up_x, up_y, up_z,
		target_x, target_y, target_z, input ready);
	modport sink(input valid, eye_x, eye_y, eye_z, up_x, up_y, up_z,
		target_x, target_y, target_z, output ready);
endinterface

interface lavm_out_if;
	logic valid;
	logic ready;
	logic [1:0] row_index;
	logic signed [31:0] col0;
	logic signed [31:0] col1;
	logic signed [31:0] col2;
	logic signed [31:0] col3;
	logic degenerate;
	logic last_row;

	modport source(output valid, row_index, col0, col1, col2, col3, degenerate,
		last_row, input ready);
	modport sink(input valid, row_index, col0, col1, col2, col3, degenerate,
		last_row, output ready);
endinterface

@@ src/look_at_view_matrix.sv @@
// top level of the fixed-point look-at view matrix block
//
// Each input transaction (eye, up, target in signed fixed point with FRAC_BITS
// fraction bits) yields three row transactions in order right, up, look; col3
// holds the saturated negated dot product of the eye with that row's axis.
// A zero-length look or right vector gives three rows of zeros with degenerate
// set. The front registers and classifies an item and a two-entry queue holds
// further items, so inputs are taken while the back is busy. The back
// sequencer works on one item at a time with one shared 32x32 multiplier, a
// two-bit-per-cycle square root and a bit-serial divider; the time for an item
// is set mostly by the 32 root steps and the FRAC_BITS+2 divide steps per
// component, plus the one-bit-per-cycle range shift of each vector. Degenerate
// items skip the dot products and go straight to row output.
module look_at_view_matrix #(
	parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	lavm_in_if.sink in_ch,
	lavm_out_if.source out_ch
);

	lavm_pkg::item_t push_item;
	lavm_pkg::item_t pop_item;
	logic push_valid;
	logic push_ready;
	logic pop_valid;
	logic pop_ready;

	lavm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.push_item(push_item),
		.push_valid(push_valid),
		.push_ready(push_ready)
	);

	lavm_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item)
	);

	lavm_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item),
		.out_ch(out_ch)
	);

endmodule

@@ src/lavm_front.sv @@
// front stage: takes a transaction, forms eye - target and flags a zero look vector
module lavm_front (
	input logic clk,
	input logic arst_n,
	lavm_in_if.sink in_ch,
	output lavm_pkg::item_t push_item,
	output logic push_valid,
	input logic push_ready
);

	lavm_pkg::item_t item_s1;
	lavm_pkg::item_t item_d;
	logic valid_s1;

	always_comb begin
		item_d.eye[0] = in_ch.eye_x;
		item_d.eye[1] = in_ch.eye_y;
		item_d.eye[2] = in_ch.eye_z;
		item_d.up[0] = in_ch.up_x;
		item_d.up[1] = in_ch.up_y;
		item_d.up[2] = in_ch.up_z;
		item_d.diff[0] = {in_ch.eye_x[31], in_ch.eye_x} - {in_ch.target_x[31], in_ch.target_x};
		item_d.diff[1] = {in_ch.eye_y[31], in_ch.eye_y} - {in_ch.target_y[31], in_ch.target_y};
		item_d.diff[2] = {in_ch.eye_z[31], in_ch.eye_z} - {in_ch.target_z[31], in_ch.target_z};
		item_d.deg = (item_d.diff[0] == '0) && (item_d.diff[1] == '0) &&
			(item_d.diff[2] == '0);
	end

	assign in_ch.ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ src/lavm_fifo.sv @@
// short queue of classified items between front and back
module lavm_fifo (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input lavm_pkg::item_t push_item,
	output logic pop_valid,
	input logic pop_ready,
	output lavm_pkg::item_t pop_item
);

	localparam int PW = $clog2(lavm_pkg::FIFO_DEPTH);

	lavm_pkg::item_t mem_q [lavm_pkg::FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = count_q != (PW+1)'(lavm_pkg::FIFO_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(lavm_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(lavm_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ src/lavm_back.sv @@
// back sequencer: normalize, cross products, translation and row output register
module lavm_back #(
	parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	output logic pop_ready,
	input lavm_pkg::item_t pop_item,
	lavm_out_if.source out_ch
);

	localparam int VW = lavm_pkg::VEC_W;
	localparam int QB = FRAC_BITS + 2;
	localparam int NW = FRAC_BITS + 32;
	localparam int CW = $clog2(QB + 1);
	localparam logic signed [VW-1:0] HALF_V = VW'(1) << (FRAC_BITS - 1);
	localparam logic signed [63:0] HALF_A = 64'(1) << (FRAC_BITS - 1);
	localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

	lavm_pkg::back_state_t state_q, state_d;

	logic [31:0] eye_q [3];
	logic [31:0] up_q [3];
	logic [31:0] look_q [3];
	logic [31:0] right_q [3];
	logic [31:0] upn_q [3];
	logic signed [VW-1:0] vec_q [3];
	logic [VW-1:0] amax_q;
	logic [63:0] rad_q;
	logic [63:0] res_q;
	logic [63:0] sbit_q;
	logic [31:0] rem_q;
	logic [QB-1:0] qn_q;
	logic [CW-1:0] dcnt_q;
	logic [1:0] comp_q;
	logic [1:0] row_q;
	logic [1:0] k_q;
	logic [2:0] j_q;
	logic second_q;
	logic deg_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] hold_q;
	logic signed [63:0] acc_q;

	logic out_valid_q;
	logic [1:0] out_row_q;
	logic [31:0] out_col_q [4];
	logic out_deg_q;
	logic out_last_q;

	logic [VW-1:0] mag [3];
	logic [VW-1:0] amax_c;
	logic amax_hi;
	logic amax_lo;
	logic [63:0] sq_try;
	logic sq_ge;
	logic [31:0] wv;
	logic w_neg;
	logic [31:0] wmag;
	logic [NW-1:0] numer;
	logic [32:0] div_t;
	logic [32:0] len33;
	logic div_ge;
	logic [QB-1:0] qn_next;
	logic [31:0] q32;
	logic [31:0] unit_c;
	logic [31:0] opa [3];
	logic [31:0] opb [3];
	logic [31:0] axis [3];
	logic [1:0] ksel;
	logic [1:0] jsel;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] rnd64;
	logic signed [63:0] neg64;
	logic [31:0] col3_c;
	logic out_free;
	logic load_row;

	// magnitude search and shift checks
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec_q[i][VW-1] ? -vec_q[i] : vec_q[i];
		end
		amax_c = mag[0];
		if (mag[1] > amax_c) begin
			amax_c = mag[1];
		end
		if (mag[2] > amax_c) begin
			amax_c = mag[2];
		end
		amax_hi = amax_q[VW-1:30] != '0;
		amax_lo = amax_q[VW-1:29] == '0;
	end

	// root and divide steps
	always_comb begin
		sq_try = res_q + sbit_q;
		sq_ge = rad_q >= sq_try;
		wv = vec_q[comp_q][31:0];
		w_neg = vec_q[comp_q][VW-1];
		wmag = w_neg ? 32'd0 - wv : wv;
		numer = (NW'(wmag[30:0]) << FRAC_BITS) + NW'(res_q[31:1]);
		div_t = {rem_q, qn_q[QB-1]};
		len33 = {1'b0, res_q[31:0]};
		div_ge = div_t >= len33;
		qn_next = {qn_q[QB-2:0], div_ge};
		q32 = 32'(qn_next);
		unit_c = w_neg ? 32'd0 - q32 : q32;
	end

	// operand selection
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			opa[i] = second_q ? look_q[i] : up_q[i];
			opb[i] = second_q ? right_q[i] : look_q[i];
		end
		case (row_q)
			lavm_pkg::ROW_RIGHT: axis = right_q;
			lavm_pkg::ROW_UP: axis = upn_q;
			default: axis = look_q;
		endcase
		ksel = (k_q < 2'd3) ? k_q : 2'd0;
		jsel = (j_q < 3'd3) ? j_q[1:0] : 2'd0;
	end

	// translation column
	always_comb begin
		rnd64 = (acc_q + HALF_A) >>> FRAC_BITS;
		neg64 = -rnd64;
		if (neg64 > SAT_HI) begin
			col3_c = SAT_HI[31:0];
		end else if (neg64 < SAT_LO) begin
			col3_c = SAT_LO[31:0];
		end else begin
			col3_c = neg64[31:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lavm_pkg::ST_IDLE: begin
				if (pop_valid) begin
					state_d = pop_item.deg ? lavm_pkg::ST_ROW : lavm_pkg::ST_NMAX;
				end
			end
			lavm_pkg::ST_NMAX: begin
				state_d = (amax_c == '0) ? lavm_pkg::ST_ROW : lavm_pkg::ST_NSHIFT;
			end
			lavm_pkg::ST_NSHIFT: begin
				if (!amax_hi && !amax_lo) begin
					state_d = lavm_pkg::ST_SQ;
				end
			end
			lavm_pkg::ST_SQ: begin
				if (k_q == 2'd3) begin
					state_d = lavm_pkg::ST_SQRT;
				end
			end
			lavm_pkg::ST_SQRT: begin
				if (sbit_q[0]) begin
					state_d = lavm_pkg::ST_DIVI;
				end
			end
			lavm_pkg::ST_DIVI: state_d = lavm_pkg::ST_DIV;
			lavm_pkg::ST_DIV: begin
				if (dcnt_q == CW'(QB - 1)) begin
					state_d = (comp_q == 2'd2) ? lavm_pkg::ST_CROSS : lavm_pkg::ST_DIVI;
				end
			end
			lavm_pkg::ST_CROSS: begin
				if (j_q == 3'd6) begin
					state_d = second_q ? lavm_pkg::ST_UPN : lavm_pkg::ST_NMAX;
				end
			end
			lavm_pkg::ST_UPN: state_d = lavm_pkg::ST_DOT;
			lavm_pkg::ST_DOT: begin
				if (j_q == 3'd3) begin
					state_d = lavm_pkg::ST_ROW;
				end
			end
			lavm_pkg::ST_ROW: begin
				if (out_free) begin
					if (row_q == lavm_pkg::ROW_LOOK) begin
						state_d = lavm_pkg::ST_IDLE;
					end else if (!deg_q) begin
						state_d = lavm_pkg::ST_DOT;
					end
				end
			end
			default: state_d = lavm_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		out_free = !out_valid_q || out_ch.ready;
		pop_ready = state_q == lavm_pkg::ST_IDLE;
		load_row = (state_q == lavm_pkg::ST_ROW) && out_free;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			lavm_pkg::ST_SQ: begin
				mul_a = vec_q[ksel][31:0];
				mul_b = vec_q[ksel][31:0];
			end
			lavm_pkg::ST_CROSS: begin
				case (j_q)
					3'd0: begin mul_a = opa[1]; mul_b = opb[2]; end
					3'd1: begin mul_a = opa[2]; mul_b = opb[1]; end
					3'd2: begin mul_a = opa[2]; mul_b = opb[0]; end
					3'd3: begin mul_a = opa[0]; mul_b = opb[2]; end
					3'd4: begin mul_a = opa[0]; mul_b = opb[1]; end
					3'd5: begin mul_a = opa[1]; mul_b = opb[0]; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			lavm_pkg::ST_DOT: begin
				mul_a = eye_q[jsel];
				mul_b = axis[jsel];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lavm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_row) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			lavm_pkg::ST_IDLE: begin
				if (pop_valid) begin
					for (int i = 0; i < 3; i++) begin
						eye_q[i] <= pop_item.eye[i];
						up_q[i] <= pop_item.up[i];
						vec_q[i] <= {{(VW - lavm_pkg::DIFF_W){pop_item.diff[i][lavm_pkg::DIFF_W-1]}},
							pop_item.diff[i]};
					end
					second_q <= 1'b0;
					deg_q <= pop_item.deg;
					row_q <= lavm_pkg::ROW_RIGHT;
				end
			end
			lavm_pkg::ST_NMAX: begin
				amax_q <= amax_c;
				if (amax_c == '0) begin
					deg_q <= 1'b1;
					row_q <= lavm_pkg::ROW_RIGHT;
				end
			end
			lavm_pkg::ST_NSHIFT: begin
				if (amax_hi) begin
					amax_q <= amax_q >> 1;
					for (int i = 0; i < 3; i++) begin
						vec_q[i] <= vec_q[i] >>> 1;
					end
				end else if (amax_lo) begin
					amax_q <= amax_q << 1;
					for (int i = 0; i < 3; i++) begin
						vec_q[i] <= vec_q[i] <<< 1;
					end
				end
				k_q <= 2'd0;
			end
			lavm_pkg::ST_SQ: begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd0) begin
					rad_q <= '0;
				end else begin
					rad_q <= rad_q + prod_q;
				end
				res_q <= '0;
				sbit_q <= 64'd1 << 62;
				comp_q <= 2'd0;
			end
			lavm_pkg::ST_SQRT: begin
				if (sq_ge) begin
					rad_q <= rad_q - sq_try;
					res_q <= (res_q >> 1) + sbit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			lavm_pkg::ST_DIVI: begin
				rem_q <= 32'(numer >> QB);
				qn_q <= numer[QB-1:0];
				dcnt_q <= '0;
			end
			lavm_pkg::ST_DIV: begin
				rem_q <= div_ge ? 32'(div_t - len33) : div_t[31:0];
				qn_q <= qn_next;
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == CW'(QB - 1)) begin
					if (second_q) begin
						right_q[comp_q] <= unit_c;
					end else begin
						look_q[comp_q] <= unit_c;
					end
					comp_q <= comp_q + 2'd1;
					j_q <= 3'd0;
				end
			end
			lavm_pkg::ST_CROSS: begin
				j_q <= j_q + 3'd1;
				case (j_q)
					3'd1, 3'd3, 3'd5: hold_q <= prod_q;
					3'd2: vec_q[0] <= VW'(hold_q - prod_q);
					3'd4: vec_q[1] <= VW'(hold_q - prod_q);
					3'd6: begin
						vec_q[2] <= VW'(hold_q - prod_q);
						second_q <= 1'b1;
					end
					default: hold_q <= hold_q;
				endcase
			end
			lavm_pkg::ST_UPN: begin
				for (int i = 0; i < 3; i++) begin
					upn_q[i] <= 32'((vec_q[i] + HALF_V) >>> FRAC_BITS);
				end
				row_q <= lavm_pkg::ROW_RIGHT;
				j_q <= 3'd0;
			end
			lavm_pkg::ST_DOT: begin
				j_q <= j_q + 3'd1;
				if (j_q == 3'd0) begin
					acc_q <= '0;
				end else begin
					acc_q <= acc_q + prod_q;
				end
			end
			lavm_pkg::ST_ROW: begin
				if (out_free) begin
					row_q <= row_q + 2'd1;
					j_q <= 3'd0;
				end
			end
			default: begin
				j_q <= j_q;
			end
		endcase
		if (load_row) begin
			out_row_q <= row_q;
			out_deg_q <= deg_q;
			out_last_q <= row_q == lavm_pkg::ROW_LOOK;
			if (deg_q) begin
				for (int i = 0; i < 4; i++) begin
					out_col_q[i] <= '0;
				end
			end else begin
				out_col_q[0] <= axis[0];
				out_col_q[1] <= axis[1];
				out_col_q[2] <= axis[2];
				out_col_q[3] <= col3_c;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.row_index = out_row_q;
	assign out_ch.col0 = out_col_q[0];
	assign out_ch.col1 = out_col_q[1];
	assign out_ch.col2 = out_col_q[2];
	assign out_ch.col3 = out_col_q[3];
	assign out_ch.degenerate = out_deg_q;
	assign out_ch.last_row = out_last_q;

endmodule
